// ===== hw/rtl/fppa_pkg.sv =====
// ----------------------------------------------------------------------------
// Partition allocator package
// Operation and register codes, fit mode codes and the structs that travel
// between the controller and the row of partition cells.
// ----------------------------------------------------------------------------
package fppa_pkg;

	// Fixed field widths of the block's ports.
	localparam int OP_W       = 2;
	localparam int LOAD_IDX_W = 4;
	localparam int VAL_W      = 16;
	localparam int OUT_IDX_W  = 4;
	localparam int FRAG_W     = 20;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	// Operation codes of an input transaction.
	localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd2;

	// Fit modes. The unused code behaves as first fit.
	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT = 1'd1;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		logic       load;
		logic       restart;
		logic       commit;
		logic [1:0] mode;
	} cell_cmd_t;

	// Control part of the search wave handed from cell to cell.
	typedef struct packed {
		logic valid;
		logic found;
	} wave_ctl_t;

endpackage

// ===== hw/rtl/fit_policy_partition_allocator.sv =====
// ----------------------------------------------------------------------------
// Fit policy partition allocator
// Fixed partitions searched by first, best or worst fit through a row of
// partition cells, with running internal and external fragmentation.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                       Payload
//  -------   -----------------------------   ------------------------------------
//  command   start in, busy out              op, load_index, load_capacity,
//                                            job_size
//  config    cfg_valid in, cfg_ready out     cfg_index, cfg_data
//  result    result_valid out (strobe)       granted, granted_index, leftover,
//                                            internal_frag, external_frag
//
// A load or restart transaction completes at the clock edge that accepts it
// and leaves busy low. An allocate transaction launches a search wave that
// moves one cell per cycle down the row of NUM_PARTS cells and then through
// the finishing stages; busy stays high until the result strobe, and the
// next command can be accepted while the strobe is shown.
// The length of the cell row sets how long the search lasts.
// Reset clears the configuration to first fit with one partition, clears the
// failure flag and idles the controller; the partition tables hold no reset
// value and must be loaded and restarted before use.
// The receiver cannot stall: each result is shown for exactly one cycle.
//
module fit_policy_partition_allocator #(
	parameter int NUM_PARTS = 16,
	parameter int CAP_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Command channel
	input  logic                                start,
	output logic                                busy,
	input  logic [fppa_pkg::OP_W-1:0]           op,
	input  logic [fppa_pkg::LOAD_IDX_W-1:0]     load_index,
	input  logic [fppa_pkg::VAL_W-1:0]          load_capacity,
	input  logic [fppa_pkg::VAL_W-1:0]          job_size,
	// Configuration channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fppa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fppa_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Result channel
	output logic                                result_valid,
	output logic                                granted,
	output logic [fppa_pkg::OUT_IDX_W-1:0]      granted_index,
	output logic [fppa_pkg::VAL_W-1:0]          leftover,
	output logic [fppa_pkg::FRAG_W-1:0]         internal_frag,
	output logic [fppa_pkg::FRAG_W-1:0]         external_frag
);
	import fppa_pkg::*;

	localparam int IDX_W = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
	localparam int CNT_W = $clog2(NUM_PARTS + 1);
	localparam int SUM_W = CAP_BITS + $clog2(NUM_PARTS + 1);
	localparam int CMP_W = (CAP_BITS > VAL_W) ? CAP_BITS : VAL_W;

	// Controller states: idle, search wave in flight, result being finished.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t                state_q;

	// Configuration registers.
	logic [1:0]            fit_mode_q;
	logic [CFG_DATA_W-1:0] part_count_q;
	logic [CNT_W-1:0]      n_used;

	// Command acceptance and broadcast to the cells.
	logic                  accept;
	logic                  launch_q;
	logic [VAL_W-1:0]      job_q;
	cell_cmd_t             cmd;

	// The search wave; entry 0 is the launch, entry i+1 is the output of
	// cell i, and the last entry is the finished search.
	wave_ctl_t             ctl_w       [NUM_PARTS+1];
	logic [IDX_W-1:0]      pick_w      [NUM_PARTS+1];
	logic [CAP_BITS-1:0]   best_free_w [NUM_PARTS+1];
	logic [CAP_BITS-1:0]   best_cap_w  [NUM_PARTS+1];
	logic [SUM_W-1:0]      int_sum_w   [NUM_PARTS+1];
	logic [SUM_W-1:0]      ext_sum_w   [NUM_PARTS+1];
	logic [NUM_PARTS:0]    wave_valid_vec;

	// Finishing logic.
	logic                  granted_c;
	logic                  old_touched;
	logic [CAP_BITS-1:0]   new_free_c;
	logic [SUM_W-1:0]      int_rm_c;
	logic [SUM_W-1:0]      ext_rm_c;
	logic                  granted_s1;
	logic [IDX_W-1:0]      pick_s1;
	logic [CAP_BITS-1:0]   new_free_s1;
	logic [CAP_BITS-1:0]   cap_s1;
	logic [SUM_W-1:0]      int_s1;
	logic [SUM_W-1:0]      ext_s1;
	logic                  new_touched;
	logic [SUM_W-1:0]      int_fin;
	logic [SUM_W-1:0]      ext_fin;
	logic                  failed_nxt;
	logic                  any_failed_q;

	// Clamp a running sum to the width of the fragmentation outputs.
	function automatic logic [FRAG_W-1:0] sat_frag(input logic [SUM_W-1:0] v);
		logic over;
		over = ((v >> FRAG_W) != '0);
		return over ? '1 : FRAG_W'(v);
	endfunction

	// ------------------------------------------------------------------
	// Configuration port. Writes are taken at any time; the user only
	// writes while the block is idle.
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q   <= FIT_FIRST;
			part_count_q <= CFG_DATA_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FIT_MODE:   fit_mode_q   <= cfg_data[1:0];
				REG_PART_COUNT: part_count_q <= cfg_data;
			endcase
		end
	end

	// A partition count above the number of cells saturates.
	assign n_used = (int'(part_count_q) > NUM_PARTS) ? CNT_W'(NUM_PARTS)
	                                                 : CNT_W'(part_count_q);

	// ------------------------------------------------------------------
	// Command acceptance. Loads and restarts act on the cells at the
	// accepting edge; an allocate launches the search wave.
	// ------------------------------------------------------------------
	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		cmd.load    = accept && (op == OP_LOAD);
		cmd.restart = accept && (op == OP_RESTART);
		cmd.commit  = (state_q == ST_FIN) && granted_s1;
		cmd.mode    = fit_mode_q;
	end

	always_ff @(posedge clk) begin
		if (accept && (op == OP_ALLOC)) begin
			job_q <= job_size;
		end
	end

	// The wave enters the first cell with nothing found and empty sums.
	always_comb begin
		ctl_w[0].valid = launch_q;
		ctl_w[0].found = 1'b0;
		pick_w[0]      = '0;
		best_free_w[0] = '0;
		best_cap_w[0]  = '0;
		int_sum_w[0]   = '0;
		ext_sum_w[0]   = '0;
	end

	// ------------------------------------------------------------------
	// Row of partition cells. Each cell holds one partition and passes the
	// best candidate so far and both partial sums to its neighbor.
	// ------------------------------------------------------------------
	for (genvar i = 0; i < NUM_PARTS; i++) begin : g_cell
		fppa_cell #(
			.INDEX     (i),
			.NUM_PARTS (NUM_PARTS),
			.CAP_BITS  (CAP_BITS)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.cmd           (cmd),
			.load_index    (load_index),
			.load_cap      (CAP_BITS'(load_capacity)),
			.job           (job_q),
			.n_used        (n_used),
			.commit_pick   (pick_s1),
			.commit_free   (new_free_s1),
			.in_ctl        (ctl_w[i]),
			.in_pick       (pick_w[i]),
			.in_best_free  (best_free_w[i]),
			.in_best_cap   (best_cap_w[i]),
			.in_int_sum    (int_sum_w[i]),
			.in_ext_sum    (ext_sum_w[i]),
			.out_ctl       (ctl_w[i+1]),
			.out_pick      (pick_w[i+1]),
			.out_best_free (best_free_w[i+1]),
			.out_best_cap  (best_cap_w[i+1]),
			.out_int_sum   (int_sum_w[i+1]),
			.out_ext_sum   (ext_sum_w[i+1])
		);
	end

	always_comb begin
		for (int i = 0; i <= NUM_PARTS; i++) begin
			wave_valid_vec[i] = ctl_w[i].valid;
		end
	end

	// ------------------------------------------------------------------
	// First finishing stage. The candidate is granted only if it holds the
	// job; for worst fit the candidate is simply the largest free amount.
	// The sums from the wave describe the table before the grant, so the
	// chosen partition's old share is taken out here and its new share is
	// added in the next stage.
	// ------------------------------------------------------------------
	always_comb begin
		granted_c   = ctl_w[NUM_PARTS].found &&
		              (CMP_W'(best_free_w[NUM_PARTS]) >= CMP_W'(job_q));
		new_free_c  = best_free_w[NUM_PARTS] - CAP_BITS'(job_q);
		old_touched = (best_free_w[NUM_PARTS] < best_cap_w[NUM_PARTS]);
		int_rm_c    = int_sum_w[NUM_PARTS] -
		              ((granted_c && old_touched) ? SUM_W'(best_free_w[NUM_PARTS]) : '0);
		ext_rm_c    = ext_sum_w[NUM_PARTS] -
		              ((granted_c && !old_touched) ? SUM_W'(best_cap_w[NUM_PARTS]) : '0);
	end

	always_ff @(posedge clk) begin
		if (ctl_w[NUM_PARTS].valid) begin
			granted_s1  <= granted_c;
			pick_s1     <= pick_w[NUM_PARTS];
			new_free_s1 <= new_free_c;
			cap_s1      <= best_cap_w[NUM_PARTS];
			int_s1      <= int_rm_c;
			ext_s1      <= ext_rm_c;
		end
	end

	// Second finishing stage: the granted partition's new free amount is
	// written back to its cell while the result registers load.
	always_comb begin
		new_touched = (new_free_s1 < cap_s1);
		int_fin     = int_s1 + ((granted_s1 && new_touched) ? SUM_W'(new_free_s1) : '0);
		ext_fin     = ext_s1 + ((granted_s1 && !new_touched) ? SUM_W'(cap_s1) : '0);
		failed_nxt  = any_failed_q || !granted_s1;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			granted       <= granted_s1;
			granted_index <= granted_s1 ? OUT_IDX_W'(pick_s1) : '0;
			leftover      <= granted_s1 ? VAL_W'(new_free_s1) : '0;
			internal_frag <= sat_frag(int_fin);
			external_frag <= failed_nxt ? sat_frag(ext_fin) : '0;
		end
	end

	// ------------------------------------------------------------------
	// Controller.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			launch_q     <= 1'b0;
			result_valid <= 1'b0;
			any_failed_q <= 1'b0;
		end else begin
			launch_q     <= accept && (op == OP_ALLOC);
			result_valid <= (state_q == ST_FIN);
			if (cmd.restart) begin
				any_failed_q <= 1'b0;
			end else if (state_q == ST_FIN) begin
				any_failed_q <= failed_nxt;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (op == OP_ALLOC)) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (ctl_w[NUM_PARTS].valid) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------

	// Only one search wave is ever in the cell row.
	a_single_wave: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(wave_valid_vec))
		else $error("more than one search wave in the cell row");

	// No wave is in flight outside the search state.
	a_wave_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_SCAN) |-> (wave_valid_vec == '0))
		else $error("search wave outside the search state");

	// Finishing a search always produces exactly one result strobe.
	a_fin_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |=> (result_valid && (state_q == ST_IDLE)))
		else $error("finished search gave no result");

	// A failed allocation reports neither a partition nor a leftover.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !granted) |-> ((granted_index == '0) && (leftover == '0)))
		else $error("failed allocation carries a partition or leftover");

endmodule

// ===== hw/rtl/fppa_cell.sv =====
// ----------------------------------------------------------------------------
// Partition cell
// Holds one partition's capacity and free amount, folds it into the search
// wave that passes through and registers the wave for the next cell.
// ----------------------------------------------------------------------------
module fppa_cell #(
	parameter int INDEX     = 0,
	parameter int NUM_PARTS = 16,
	parameter int CAP_BITS  = 16,
	localparam int IDX_W    = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1,
	localparam int CNT_W    = $clog2(NUM_PARTS + 1),
	localparam int SUM_W    = CAP_BITS + $clog2(NUM_PARTS + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fppa_pkg::cell_cmd_t                 cmd,
	input  logic [fppa_pkg::LOAD_IDX_W-1:0]     load_index,
	input  logic [CAP_BITS-1:0]                 load_cap,
	input  logic [fppa_pkg::VAL_W-1:0]          job,
	input  logic [CNT_W-1:0]                    n_used,
	input  logic [IDX_W-1:0]                    commit_pick,
	input  logic [CAP_BITS-1:0]                 commit_free,
	input  fppa_pkg::wave_ctl_t                 in_ctl,
	input  logic [IDX_W-1:0]                    in_pick,
	input  logic [CAP_BITS-1:0]                 in_best_free,
	input  logic [CAP_BITS-1:0]                 in_best_cap,
	input  logic [SUM_W-1:0]                    in_int_sum,
	input  logic [SUM_W-1:0]                    in_ext_sum,
	output fppa_pkg::wave_ctl_t                 out_ctl,
	output logic [IDX_W-1:0]                    out_pick,
	output logic [CAP_BITS-1:0]                 out_best_free,
	output logic [CAP_BITS-1:0]                 out_best_cap,
	output logic [SUM_W-1:0]                    out_int_sum,
	output logic [SUM_W-1:0]                    out_ext_sum
);
	import fppa_pkg::*;

	localparam int CMP_W = (CAP_BITS > VAL_W) ? CAP_BITS : VAL_W;

	logic [CAP_BITS-1:0] cap_q;
	logic [CAP_BITS-1:0] free_q;
	logic                in_use;
	logic                touched;
	logic                fits;
	logic                take;
	logic                active;
	logic                load_hit;
	logic                commit_hit;

	always_comb begin
		in_use     = (INDEX < int'(n_used));
		active     = in_ctl.valid && in_use;
		touched    = (free_q < cap_q);
		fits       = (CMP_W'(free_q) >= CMP_W'(job));
		load_hit   = (INDEX < (2 ** LOAD_IDX_W)) && (load_index == LOAD_IDX_W'(INDEX));
		commit_hit = (commit_pick == IDX_W'(INDEX));
		take       = 1'b0;
		if (active) begin
			unique case (cmd.mode)
				FIT_WORST: take = !in_ctl.found || (free_q > in_best_free);
				FIT_BEST:  take = fits && (!in_ctl.found || (free_q < in_best_free));
				default:   take = fits && !in_ctl.found;
			endcase
		end
	end

	// Partition storage; the free amount is reloaded on restart and
	// replaced by the controller when this partition is granted.
	always_ff @(posedge clk) begin
		if (cmd.load && load_hit) begin
			cap_q <= load_cap;
		end
		if (cmd.restart) begin
			free_q <= cap_q;
		end else if (cmd.commit && commit_hit) begin
			free_q <= commit_free;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ctl <= '0;
		end else begin
			out_ctl.valid <= in_ctl.valid;
			out_ctl.found <= in_ctl.found || take;
		end
	end

	always_ff @(posedge clk) begin
		out_pick      <= take ? IDX_W'(INDEX) : in_pick;
		out_best_free <= take ? free_q : in_best_free;
		out_best_cap  <= take ? cap_q : in_best_cap;
		out_int_sum   <= in_int_sum + ((active && touched) ? SUM_W'(free_q) : '0);
		out_ext_sum   <= in_ext_sum + ((active && !touched) ? SUM_W'(cap_q) : '0);
	end

endmodule
